// ===== rtl/core/bilinear_image_scaler_assert.svh =====
// Assertion macros for the bilinear image scaler.
// Used by the top level; no other dependencies.
`ifndef BILINEAR_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_ASSERT_SVH
`ifndef SYNTHESIS
`define BIS_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("bilinear_image_scaler assertion failed");
`define BIS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("bilinear_image_scaler assertion failed");
`else
`define BIS_ASSERT_IMPLIES(label, clk, rst, a, b)
`define BIS_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/core/bis_pkg.sv =====
// Shared constants, register codes and types of the bilinear image scaler.
// No dependencies.
package bis_pkg;

   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int MAX_DST_DIM    = 4096;
   localparam int MAX_CHANNELS   = 4;

   localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SRC_POS_W   = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                                $clog2(MAX_SRC_WIDTH) : $clog2(MAX_SRC_HEIGHT);
   localparam int SRC_DIM_W   = SRC_POS_W + 1;
   localparam int DST_POS_W   = $clog2(MAX_DST_DIM);
   localparam int DST_DIM_W   = DST_POS_W + 1;
   localparam int CH_W        = 3;
   localparam int FRAC_W      = 16;
   localparam int NUM_W       = DST_POS_W + SRC_POS_W;
   localparam int DIVD_W      = NUM_W + FRAC_W;
   localparam int DIV_CNT_W   = $clog2(DIVD_W);
   localparam int TOTAL_W     = ADDR_W + 1;

   // Register indexes of the configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DST_DIM_W;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS   = 3'd4;

   localparam int OP_LOAD = 0;
   localparam int OP_EMIT = 1;

   // Divider status toward the sequencer
   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quot;
   } div_result_type;

endpackage

// ===== rtl/core/bis_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the scaler's position map.
// Depends on bis_pkg.
module bis_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bis_pkg::DIVD_W-1:0]     dividend,
   input  logic [bis_pkg::DST_DIM_W-1:0]  divisor,
   output bis_pkg::div_result_type        result
);

   logic [bis_pkg::DIVD_W-1:0]    quo_ff, quo_in;
   logic [bis_pkg::DST_DIM_W-1:0] rem_ff, rem_in;
   logic [bis_pkg::DST_DIM_W-1:0] dsr_ff, dsr_in;
   logic [bis_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [bis_pkg::DST_DIM_W:0]   trial;
   logic                          fits;

   // Shift in one dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[bis_pkg::DIVD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = bis_pkg::DIV_CNT_W'(bis_pkg::DIVD_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? bis_pkg::DST_DIM_W'(trial - {1'b0, dsr_ff})
                       : bis_pkg::DST_DIM_W'(trial);
         quo_in = {quo_ff[bis_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign result.done = done_ff;
   assign result.quot = quo_ff;

endmodule

// ===== rtl/core/bilinear_image_scaler.sv =====
// Top level of the bilinear image scaler: registers, source memory, sequencer.
// Depends on bis_pkg, bis_divider and bilinear_image_scaler_assert.svh.
//
//   channel   ports                           handshake
//   request   req_op, req_in_ch0..3           start & !busy
//   result    rsp_out_ch0..3, rsp_last_pixel  rsp_valid, one cycle, no stall
//   csr       csr_index, csr_wdata            csr_valid & csr_ready
//
// A load request leaves busy low.
// An emit request runs through the 36-step divider, the four reads of the
// source memory and three multiply steps per channel.
// Reset is synchronous; the source memory is not cleared and needs no sweep.
// Results are strobed for one cycle; the receiver cannot stall them.
`include "bilinear_image_scaler_assert.svh"
module bilinear_image_scaler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic [7:0]                       req_in_ch0,
   input  logic [7:0]                       req_in_ch1,
   input  logic [7:0]                       req_in_ch2,
   input  logic [7:0]                       req_in_ch3,
   output logic                             rsp_valid,
   output logic [7:0]                       rsp_out_ch0,
   output logic [7:0]                       rsp_out_ch1,
   output logic [7:0]                       rsp_out_ch2,
   output logic [7:0]                       rsp_out_ch3,
   output logic                             rsp_last_pixel,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bis_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_ADDR   = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_INTERP = 3'd5;

   localparam int SPW = bis_pkg::SRC_POS_W;
   localparam int SDW = bis_pkg::SRC_DIM_W;
   localparam int DPW = bis_pkg::DST_POS_W;
   localparam int DDW = bis_pkg::DST_DIM_W;
   localparam int AW  = bis_pkg::ADDR_W;
   localparam int FW  = bis_pkg::FRAC_W;
   localparam int NW  = bis_pkg::NUM_W;

   // Configuration registers
   logic [SDW-1:0]              src_width_ff, src_height_ff;
   logic [DDW-1:0]              dst_width_ff, dst_height_ff;
   logic [bis_pkg::CH_W-1:0]    channels_ff;

   // Sequencer and datapath registers
   logic [2:0]                  state_ff, state_in;
   logic [AW-1:0]               load_pos_ff, load_pos_in;
   logic [DPW-1:0]              col_ff, col_in, row_ff, row_in;
   logic [NW-1:0]               nx_ff, nx_in, ny_ff, ny_in;
   logic                        last_ff, last_in;
   logic [SPW-1:0]              x0_ff, x0_in, x1_ff, x1_in;
   logic [AW-1:0]               row0_ff, row0_in, row1_ff, row1_in;
   logic [FW-1:0]               fx_ff, fx_in, fy_ff, fy_in;
   logic [2:0]                  rd_cnt_ff, rd_cnt_in;
   logic [31:0]                 word_ff [4];
   logic [1:0]                  ch_ff, ch_in;
   logic [1:0]                  step_ff, step_in;
   logic signed [26:0]          top_ff, top_in, bot_ff, bot_in;
   logic [7:0]                  out_ff [4];
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_last_ff;

   // Source memory
   logic [31:0]                 store_mem [bis_pkg::STORE_DEPTH];
   logic [31:0]                 rdata_ff;
   logic [AW-1:0]               raddr;
   logic                        mem_we;
   logic [AW-1:0]               waddr;

   // Effective sizes
   logic [SDW-1:0]              sw, sh;
   logic [DDW-1:0]              dw, dh;
   logic [bis_pkg::CH_W-1:0]    nch;
   logic [SPW-1:0]              sw_m1, sh_m1;
   logic [bis_pkg::TOTAL_W-1:0] total;

   logic                        accept;
   logic [DPW-1:0]              col_eff, row_eff;
   bis_pkg::div_result_type     div_x_res, div_y_res;
   logic [SPW-1:0]              qx, qy, y0_c, y1_c;

   // Interpolation datapath
   logic [7:0]                  pix_a, pix_b;
   logic signed [8:0]           hdiff;
   logic signed [25:0]          hprod;
   logic signed [26:0]          hsum;
   logic signed [26:0]          vdiff;
   logic signed [43:0]          vprod;
   logic signed [43:0]          vsum;
   logic [7:0]                  vres;

   assign accept    = start && !busy;
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;

   // Clamp the size registers to their ranges
   always_comb begin
      sw  = (src_width_ff == '0) ? SDW'(1) :
            (src_width_ff > SDW'(bis_pkg::MAX_SRC_WIDTH)) ?
            SDW'(bis_pkg::MAX_SRC_WIDTH) : src_width_ff;
      sh  = (src_height_ff == '0) ? SDW'(1) :
            (src_height_ff > SDW'(bis_pkg::MAX_SRC_HEIGHT)) ?
            SDW'(bis_pkg::MAX_SRC_HEIGHT) : src_height_ff;
      dw  = (dst_width_ff == '0) ? DDW'(1) :
            (dst_width_ff > DDW'(bis_pkg::MAX_DST_DIM)) ?
            DDW'(bis_pkg::MAX_DST_DIM) : dst_width_ff;
      dh  = (dst_height_ff == '0) ? DDW'(1) :
            (dst_height_ff > DDW'(bis_pkg::MAX_DST_DIM)) ?
            DDW'(bis_pkg::MAX_DST_DIM) : dst_height_ff;
      nch = (channels_ff == '0) ? bis_pkg::CH_W'(1) :
            (channels_ff > bis_pkg::CH_W'(bis_pkg::MAX_CHANNELS)) ?
            bis_pkg::CH_W'(bis_pkg::MAX_CHANNELS) : channels_ff;
      sw_m1 = SPW'(sw - 1'b1);
      sh_m1 = SPW'(sh - 1'b1);
      total = bis_pkg::TOTAL_W'(sw * sh);
   end

   // Drop stale destination counters
   assign col_eff = ({1'b0, col_ff} >= dw) ? '0 : col_ff;
   assign row_eff = ({1'b0, row_ff} >= dh) ? '0 : row_ff;

   // Position dividers: quotient holds integer part over a Q16 fraction
   bis_divider u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_START),
      .dividend ({nx_ff, FW'(0)}),
      .divisor  (dw),
      .result   (div_x_res)
   );

   bis_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_START),
      .dividend ({ny_ff, FW'(0)}),
      .divisor  (dh),
      .result   (div_y_res)
   );

   assign qx = div_x_res.quot[FW +: SPW];
   assign qy = div_y_res.quot[FW +: SPW];
   assign y0_c = (qy > sh_m1) ? sh_m1 : qy;
   assign y1_c = ({1'b0, y0_c} + 1'b1 < sh) ? SPW'(y0_c + 1'b1) : sh_m1;

   // Read address for the four neighbors
   always_comb begin
      unique case (rd_cnt_ff[1:0])
         2'd0:    raddr = AW'(row0_ff + x0_ff);
         2'd1:    raddr = AW'(row0_ff + x1_ff);
         2'd2:    raddr = AW'(row1_ff + x0_ff);
         default: raddr = AW'(row1_ff + x1_ff);
      endcase
   end

   // Horizontal blend on a multiplier shared by top and bottom rows, vertical blend on a second one
   always_comb begin
      pix_a = (step_ff == 2'd0) ? word_ff[0][{ch_ff, 3'b000} +: 8] :
                                  word_ff[2][{ch_ff, 3'b000} +: 8];
      pix_b = (step_ff == 2'd0) ? word_ff[1][{ch_ff, 3'b000} +: 8] :
                                  word_ff[3][{ch_ff, 3'b000} +: 8];
      hdiff = $signed({1'b0, pix_b}) - $signed({1'b0, pix_a});
      hprod = hdiff * $signed({1'b0, fx_ff});
      hsum  = $signed({3'b000, pix_a, FW'(0)}) + 27'(hprod);
      vdiff = bot_ff - top_ff;
      vprod = 44'(vdiff * $signed({1'b0, fy_ff}));
      vsum  = $signed({top_ff, FW'(0)}) + vprod;
      vres  = vsum[39:32];
   end

   assign mem_we = accept && (req_op == 1'(bis_pkg::OP_LOAD));
   assign waddr  = ({1'b0, load_pos_ff} >= total) ? '0 : load_pos_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      last_in      = last_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      row0_in      = row0_ff;
      row1_in      = row1_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      rd_cnt_in    = rd_cnt_ff;
      ch_in        = ch_ff;
      step_in      = step_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (mem_we) begin
               // advance the load position, wrap at the image size
               load_pos_in = ({1'b0, waddr} + 1'b1 >= total) ? '0 : AW'(waddr + 1'b1);
            end else if (accept) begin
               nx_in   = NW'(col_eff * sw_m1);
               ny_in   = NW'(row_eff * sh_m1);
               last_in = ({1'b0, col_eff} == dw - 1'b1) && ({1'b0, row_eff} == dh - 1'b1);
               if ({1'b0, col_eff} + 1'b1 >= dw) begin
                  col_in = '0;
                  row_in = ({1'b0, row_eff} + 1'b1 >= dh) ? '0 : DPW'(row_eff + 1'b1);
               end else begin
                  col_in = DPW'(col_eff + 1'b1);
                  row_in = row_eff;
               end
               state_in = S_START;
            end
         end
         S_START: state_in = S_DIV;
         S_DIV: begin
            if (div_x_res.done && div_y_res.done) begin
               x0_in    = (qx > sw_m1) ? sw_m1 : qx;
               x1_in    = ({1'b0, ((qx > sw_m1) ? sw_m1 : qx)} + 1'b1 < sw) ?
                          SPW'(((qx > sw_m1) ? sw_m1 : qx) + 1'b1) : sw_m1;
               fx_in    = div_x_res.quot[FW-1:0];
               fy_in    = div_y_res.quot[FW-1:0];
               row0_in  = AW'(y0_c * sw);
               row1_in  = AW'(y1_c * sw);
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            rd_cnt_in = '0;
            state_in  = S_READ;
         end
         S_READ: begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == 3'd4) begin
               ch_in    = '0;
               step_in  = '0;
               state_in = S_INTERP;
            end
         end
         S_INTERP: begin
            unique case (step_ff)
               2'd0:    begin top_in = hsum; step_in = 2'd1; end
               2'd1:    begin bot_in = hsum; step_in = 2'd2; end
               default: begin
                  step_in = 2'd0;
                  ch_in   = ch_ff + 1'b1;
                  if (ch_ff == 2'd3) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Source memory: one write and one read a cycle, registered read data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[waddr] <= {req_in_ch3, req_in_ch2, req_in_ch1, req_in_ch0};
      end
      rdata_ff <= store_mem[raddr];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      last_ff <= last_in;
      x0_ff   <= x0_in;
      x1_ff   <= x1_in;
      row0_ff <= row0_in;
      row1_ff <= row1_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      top_ff  <= top_in;
      bot_ff  <= bot_in;
      ch_ff   <= ch_in;
      step_ff <= step_in;
      rd_cnt_ff <= rd_cnt_in;
      // capture neighbor words in the cycle after their read
      if (state_ff == S_READ && rd_cnt_ff != 3'd0) begin
         word_ff[rd_cnt_ff[1:0] - 2'd1] <= rdata_ff;
      end
      if (state_ff == S_INTERP && step_ff == 2'd2) begin
         out_ff[ch_ff] <= ({1'b0, ch_ff} < nch) ? vres : 8'd0;
      end
      if (rsp_valid_in) begin
         rsp_last_ff <= last_ff;
      end
   end

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         load_pos_ff   <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= SDW'(256);
         src_height_ff <= SDW'(256);
         dst_width_ff  <= DDW'(256);
         dst_height_ff <= DDW'(256);
         channels_ff   <= bis_pkg::CH_W'(4);
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               bis_pkg::REG_SRC_WIDTH:  src_width_ff  <= csr_wdata[SDW-1:0];
               bis_pkg::REG_SRC_HEIGHT: src_height_ff <= csr_wdata[SDW-1:0];
               bis_pkg::REG_DST_WIDTH:  dst_width_ff  <= csr_wdata[DDW-1:0];
               bis_pkg::REG_DST_HEIGHT: dst_height_ff <= csr_wdata[DDW-1:0];
               bis_pkg::REG_CHANNELS:   channels_ff   <= csr_wdata[bis_pkg::CH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_ch0    = out_ff[0];
   assign rsp_out_ch1    = out_ff[1];
   assign rsp_out_ch2    = out_ff[2];
   assign rsp_out_ch3    = out_ff[3];
   assign rsp_last_pixel = rsp_last_ff;

   `BIS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `BIS_ASSERT_IMPLIES(a_result_idle, clock, reset, rsp_valid, !busy)
   `BIS_ASSERT_NEXT(a_emit_busy, clock, reset, start && !busy && req_op, busy)
   `BIS_ASSERT_NEXT(a_load_free, clock, reset, start && !busy && !req_op, !busy)

endmodule

// ===== sim/bilinear_image_scaler_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the bilinear image scaler: directed and random requests.
// Depends on bis_pkg and the bilinear_image_scaler RTL.

// Tracks the expected destination pixels of the scaler from the accepted requests
class resize_scoreboard;
   typedef struct {
      logic [7:0] ch[4];
      logic       last;
   } pixel_type;

   bit [31:0]   pixels [0:65535];
   bit          loaded [0:65535];
   int unsigned load_pos, col, row;
   int unsigned src_w, src_h, dst_w, dst_h, nch;
   pixel_type   pending[$];
   int          errors;

   function new();
      load_pos = 0; col = 0; row = 0;
      src_w = 256; src_h = 256; dst_w = 256; dst_h = 256; nch = 4;
      errors = 0;
   endfunction

   function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Mirror a register write; unknown indexes are dropped
   function void write_reg(logic [bis_pkg::CSR_IDX_W-1:0] idx,
                           logic [bis_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         bis_pkg::REG_SRC_WIDTH:  src_w = data & 13'h1ff;
         bis_pkg::REG_SRC_HEIGHT: src_h = data & 13'h1ff;
         bis_pkg::REG_DST_WIDTH:  dst_w = data & 13'h1fff;
         bis_pkg::REG_DST_HEIGHT: dst_h = data & 13'h1fff;
         bis_pkg::REG_CHANNELS:   nch   = data & 13'h7;
         default: ;
      endcase
   endfunction

   // True once every source pixel of the current size holds data
   function bit image_loaded();
      int unsigned total;
      total = clamp_dim(src_w, bis_pkg::MAX_SRC_WIDTH) *
              clamp_dim(src_h, bis_pkg::MAX_SRC_HEIGHT);
      for (int unsigned i = 0; i < total; i++)
         if (!loaded[i]) return 0;
      return 1;
   endfunction

   // Note an accepted request: store a pixel or predict the next output pixel
   function void note_request(bit op, logic [7:0] c0, logic [7:0] c1,
                              logic [7:0] c2, logic [7:0] c3);
      int unsigned sw, sh, dw, dh, n, total, x0, y0, x1, y1;
      longint unsigned nx, ny, fx, fy, top, bot;
      bit [31:0] w00, w01, w10, w11;
      pixel_type px;
      sw = clamp_dim(src_w, bis_pkg::MAX_SRC_WIDTH);
      sh = clamp_dim(src_h, bis_pkg::MAX_SRC_HEIGHT);
      dw = clamp_dim(dst_w, bis_pkg::MAX_DST_DIM);
      dh = clamp_dim(dst_h, bis_pkg::MAX_DST_DIM);
      n  = clamp_dim(nch, bis_pkg::MAX_CHANNELS);
      total = sw * sh;
      if (op == bis_pkg::OP_LOAD) begin
         if (load_pos >= total) load_pos = 0;
         pixels[load_pos] = {c3, c2, c1, c0};
         loaded[load_pos] = 1;
         load_pos = (load_pos + 1 >= total) ? 0 : load_pos + 1;
         return;
      end
      if (col >= dw) col = 0;
      if (row >= dh) row = 0;
      nx = longint'(col) * (sw - 1);
      ny = longint'(row) * (sh - 1);
      x0 = nx / dw;
      y0 = ny / dh;
      fx = ((nx % dw) << 16) / dw;
      fy = ((ny % dh) << 16) / dh;
      if (x0 > sw - 1) x0 = sw - 1;
      if (y0 > sh - 1) y0 = sh - 1;
      x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
      y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
      w00 = pixels[y0 * sw + x0];
      w01 = pixels[y0 * sw + x1];
      w10 = pixels[y1 * sw + x0];
      w11 = pixels[y1 * sw + x1];
      for (int c = 0; c < 4; c++) begin
         if (c < n) begin
            top = longint'(w00[c*8 +: 8]) * (65536 - fx) + longint'(w01[c*8 +: 8]) * fx;
            bot = longint'(w10[c*8 +: 8]) * (65536 - fx) + longint'(w11[c*8 +: 8]) * fx;
            px.ch[c] = (top * (65536 - fy) + bot * fy) >> 32;
         end else begin
            px.ch[c] = 8'd0;
         end
      end
      px.last = (col == dw - 1) && (row == dh - 1);
      if (col + 1 >= dw) begin
         col = 0;
         row = (row + 1 >= dh) ? 0 : row + 1;
      end else begin
         col = col + 1;
      end
      pending.push_back(px);
   endfunction

   // Compare an output pixel with the oldest prediction
   function void check_result(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                              logic [7:0] c3, logic last);
      pixel_type px;
      logic [7:0] got[4];
      if (pending.size() == 0) begin
         $error("unexpected output pixel");
         errors++;
         return;
      end
      px = pending.pop_front();
      got = '{c0, c1, c2, c3};
      for (int c = 0; c < 4; c++)
         if (got[c] !== px.ch[c]) begin
            $error("out_ch%0d: expected %0d, got %0d", c, px.ch[c], got[c]);
            errors++;
         end
      if (last !== px.last) begin
         $error("last_pixel: expected %0d, got %0d", px.last, last);
         errors++;
      end
   endfunction
endclass

module bilinear_image_scaler_tb;

   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [bis_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd5;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_op = 0;
   logic [7:0] req_in_ch0 = 0, req_in_ch1 = 0, req_in_ch2 = 0, req_in_ch3 = 0;
   logic rsp_valid;
   logic [7:0] rsp_out_ch0, rsp_out_ch1, rsp_out_ch2, rsp_out_ch3;
   logic rsp_last_pixel;
   logic csr_valid = 0;
   logic csr_ready;
   logic [bis_pkg::CSR_IDX_W-1:0] csr_index = 0;
   logic [bis_pkg::CSR_DATA_W-1:0] csr_wdata = 0;

   resize_scoreboard scoreboard = new();
   int idle_cycles = 0;
   int max_gap = 18;
   int requests = 0;

   bilinear_image_scaler dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Check every output pixel at the edge that ends its strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         scoreboard.check_result(rsp_out_ch0, rsp_out_ch1, rsp_out_ch2, rsp_out_ch3,
                                 rsp_last_pixel);
   end

   // Abort when no handshake of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Drive one request after a random gap and hold it until accepted
   task automatic send_request(bit op, logic [7:0] c0, logic [7:0] c1,
                               logic [7:0] c2, logic [7:0] c3);
      int gap;
      gap = (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
      @(negedge clock);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      start <= 1;
      req_op <= op;
      req_in_ch0 <= c0; req_in_ch1 <= c1; req_in_ch2 <= c2; req_in_ch3 <= c3;
      do @(posedge clock); while (busy);
      scoreboard.note_request(op, c0, c1, c2, c3);
      requests++;
   endtask

   // Drop start and wait until every predicted pixel has come out
   task automatic drain();
      @(negedge clock);
      start <= 0;
      do @(posedge clock); while (scoreboard.pending.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [bis_pkg::CSR_IDX_W-1:0] idx,
                            logic [bis_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      scoreboard.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic configure(int sw, int sh, int dw, int dh, int nch);
      drain();
      write_csr(bis_pkg::REG_SRC_WIDTH, sw);
      write_csr(bis_pkg::REG_SRC_HEIGHT, sh);
      write_csr(bis_pkg::REG_DST_WIDTH, dw);
      write_csr(bis_pkg::REG_DST_HEIGHT, dh);
      write_csr(bis_pkg::REG_CHANNELS, nch);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7, 0))
         0: return 8'h00;
         1: return 8'hff;
         default: return $urandom_range(255, 0);
      endcase
   endfunction

   // Issue a random request; emit only once the whole source image holds data
   task automatic random_request(int emit_pct);
      bit op;
      op = ($urandom_range(99, 0) < emit_pct) && scoreboard.image_loaded();
      send_request(op, pick_byte(), pick_byte(), pick_byte(), pick_byte());
   endtask

   initial begin
      int sw, sh, dw, dh, nch, n;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: 2x2 source with extreme bytes scaled to 3x3, one wrap
      configure(2, 2, 3, 3, 4);
      write_csr(REG_SPARE, 13'h1fff);
      send_request(bis_pkg::OP_LOAD, 8'h00, 8'hff, 8'h00, 8'hff);
      send_request(bis_pkg::OP_LOAD, 8'hff, 8'h00, 8'hff, 8'h00);
      send_request(bis_pkg::OP_LOAD, 8'hff, 8'hff, 8'h00, 8'h00);
      send_request(bis_pkg::OP_LOAD, 8'h00, 8'h00, 8'hff, 8'hff);
      repeat (10) send_request(bis_pkg::OP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);

      // Directed: zero sizes clamp to one pixel, zero channels clamps to one
      configure(0, 1, 0, 0, 0);
      send_request(bis_pkg::OP_LOAD, 8'h5a, 8'ha5, 8'h3c, 8'hc3);
      repeat (2) send_request(bis_pkg::OP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);

      // Directed: oversize values clamp to the maximum; single row source
      configure(511, 1, 8191, 2, 7);
      for (int i = 0; i < 256; i++)
         send_request(bis_pkg::OP_LOAD, i, 255 - i, i ^ 8'h55, i ^ 8'haa);
      repeat (6) send_request(bis_pkg::OP_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);

      // Random phases with varied sizes, stale counters and varied pacing
      while (requests < 1780) begin
         if ($urandom_range(9, 0) == 0) begin
            sw = 1; sh = $urandom_range(256, 200);
            if ($urandom_range(1, 0)) begin sw = sh; sh = 1; end
         end else begin
            sw = $urandom_range(8, 1); sh = $urandom_range(8, 1);
         end
         case ($urandom_range(9, 0))
            0: begin dw = 4096; dh = $urandom_range(3, 0); end
            1: begin dw = $urandom_range(8191, 4097); dh = 0; end
            default: begin dw = $urandom_range(12, 1); dh = $urandom_range(12, 1); end
         endcase
         nch = $urandom_range(7, 0);
         configure(sw, sh, dw, dh, nch);
         max_gap = ($urandom_range(2, 0) == 0) ? 0 : 18;
         n = $urandom_range(120, 40);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(29, 0) == 0) drain();
            random_request(60);
         end
      end

      drain();
      if (scoreboard.errors == 0 && scoreboard.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bis_pkg.sv
rtl/core/bis_divider.sv
rtl/core/bilinear_image_scaler.sv
sim/bilinear_image_scaler_tb.sv
